/* design/histeq_pkg.sv */
// Shared types, codes and constants of the histogram equalizer.
package histeq_pkg;

   // Fixed field widths of the request and response channels.
   localparam int PIXEL_W  = 12;
   localparam int MAPPED_W = 12;

   // Defaults for the top-level parameters.
   localparam int DEF_LEVELS     = 4096;
   localparam int DEF_MAX_PIXELS = 1048576;

   // Request type codes.
   localparam logic REQ_ACCUM = 1'b0;
   localparam logic REQ_MAP   = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic acc_fire;   // accumulate transaction accepted
      logic map_fire;   // map transaction accepted
      logic clr_wr;     // write zero to the histogram at the level index
      logic cum_add;    // add the histogram entry to the running sum
      logic mul_load;   // form the scaled numerator and load the divider
      logic div_step;   // one quotient bit of the divider
      logic map_wr;     // write the quotient into the level map
      logic finish;     // end of the build: clear the pass counters
   } histeq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;  // the map read stage can take a new transaction
   } histeq_sts_type;

endpackage

/* design/histeq_ctrl.sv */
// Controller state machine of the histogram equalizer.
module histeq_ctrl #(
   parameter int LEVELS = histeq_pkg::DEF_LEVELS,
   parameter int LVL_W  = $clog2(LEVELS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic                       req_last,
   input  histeq_pkg::histeq_sts_type sts,
   output histeq_pkg::histeq_cmd_type cmd,
   output logic [LVL_W-1:0]           idx
);
   import histeq_pkg::*;

   localparam int STP_W = $clog2(LVL_W + 1);
   localparam logic [LVL_W-1:0] IDX_TOP = LVL_W'(LEVELS - 1);
   localparam logic [STP_W-1:0] STP_TOP = STP_W'(LVL_W - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_B_RD,
      ST_B_ACC,
      ST_B_MUL,
      ST_B_DIV,
      ST_B_WR
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] idx_ff, idx_in;
   logic [STP_W-1:0] step_ff, step_in;

   assign idx = idx_ff;

   // Next state, commands and the handshake.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (idx_ff == IDX_TOP) begin
               idx_in   = '0;
               state_in = ST_RUN;
            end else begin
               idx_in = LVL_W'(idx_ff + 1'b1);
            end
         end
         ST_RUN: begin
            req_ready = sts.slot_free;
            if (req_valid && sts.slot_free) begin
               if (req_type == REQ_MAP) begin
                  cmd.map_fire = 1'b1;
               end else begin
                  cmd.acc_fire = 1'b1;
                  if (req_last) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            // The increment of the final pixel lands in this cycle.
            idx_in   = '0;
            state_in = ST_B_RD;
         end
         ST_B_RD: begin
            cmd.clr_wr = 1'b1;
            state_in   = ST_B_ACC;
         end
         ST_B_ACC: begin
            cmd.cum_add = 1'b1;
            state_in    = ST_B_MUL;
         end
         ST_B_MUL: begin
            cmd.mul_load = 1'b1;
            step_in      = STP_TOP;
            state_in     = ST_B_DIV;
         end
         ST_B_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_B_WR;
            end else begin
               step_in = STP_W'(step_ff - 1'b1);
            end
         end
         ST_B_WR: begin
            cmd.map_wr = 1'b1;
            if (idx_ff == IDX_TOP) begin
               cmd.finish = 1'b1;
               idx_in     = '0;
               state_in   = ST_RUN;
            end else begin
               idx_in   = LVL_W'(idx_ff + 1'b1);
               state_in = ST_B_RD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and sequencing counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTHESIS
   // The final pixel of a pass closes the request channel for the build.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc_fire && req_last) |=> !req_ready)
      else $error("request channel open after the final pixel");

   // Every build starts its walk at level zero.
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_B_RD && idx_ff == '0))
      else $error("build walk does not start at level zero");

   // A map write is followed by the next level or the end of the build.
   a_after_write: assert property (@(posedge clock) disable iff (reset)
      cmd.map_wr |=> (state_ff == ST_RUN || state_ff == ST_B_RD))
      else $error("unexpected state after a map write");
`endif

endmodule

/* design/histeq_dp.sv */
// Datapath of the histogram equalizer: stores, counters, divider and output register.
module histeq_dp #(
   parameter int LEVELS     = histeq_pkg::DEF_LEVELS,
   parameter int MAX_PIXELS = histeq_pkg::DEF_MAX_PIXELS,
   parameter int LVL_W      = $clog2(LEVELS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [histeq_pkg::PIXEL_W-1:0]     req_pixel,
   input  histeq_pkg::histeq_cmd_type         cmd,
   input  logic [LVL_W-1:0]                   idx,
   output histeq_pkg::histeq_sts_type         sts,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [histeq_pkg::MAPPED_W-1:0]    rsp_mapped
);
   import histeq_pkg::*;

   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int NUM_W = CNT_W + LVL_W;
   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

   logic [CNT_W-1:0]    hist_mem [LEVELS];
   logic [MAPPED_W-1:0] map_mem  [LEVELS];

   logic [LVL_W-1:0]    req_idx;
   logic                counted;
   logic                hist_we;
   logic [LVL_W-1:0]    hist_wa, hist_ra;
   logic [CNT_W-1:0]    hist_wd, inc_val;
   logic [CNT_W-1:0]    hist_rd_ff;
   logic                inc_pend_ff;
   logic [LVL_W-1:0]    inc_addr_ff;
   logic                fwd_ff;
   logic [CNT_W-1:0]    fwd_data_ff;
   logic [CNT_W-1:0]    total_ff, cum_ff;
   logic                built_ff;
   logic [NUM_W-1:0]    num;
   logic [CNT_W:0]      div_shift;
   logic                div_ge;
   logic [CNT_W-1:0]    div_rem_ff, div_rem_in;
   logic [LVL_W-1:0]    div_lo_ff, div_lo_in;
   logic [MAPPED_W-1:0] map_wd;
   logic                mrd_ff, mrd_zero_ff;
   logic [MAPPED_W-1:0] map_rd_ff;
   logic                rsp_valid_ff;
   logic [MAPPED_W-1:0] rsp_mapped_ff;
   logic                rsp_load;

   // A pixel above the top level saturates to it.
   always_comb begin
      if (32'(req_pixel) > LEVELS - 1) begin
         req_idx = LVL_TOP;
      end else begin
         req_idx = LVL_W'(req_pixel);
      end
   end

   assign counted = total_ff < CNT_MAX;

   // Histogram port selection: clearing writes zero, otherwise the pending increment.
   assign inc_val = CNT_W'((fwd_ff ? fwd_data_ff : hist_rd_ff) + 1'b1);
   assign hist_we = cmd.clr_wr || inc_pend_ff;
   assign hist_wa = cmd.clr_wr ? idx : inc_addr_ff;
   assign hist_wd = cmd.clr_wr ? '0 : inc_val;
   assign hist_ra = cmd.clr_wr ? idx : req_idx;

   // Histogram store with registered read.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   // Increment pipeline; a write in flight to the same level is forwarded.
   always_ff @(posedge clock) begin
      if (reset) begin
         inc_pend_ff <= 1'b0;
      end else begin
         inc_pend_ff <= cmd.acc_fire && counted;
      end
      if (cmd.acc_fire) begin
         inc_addr_ff <= req_idx;
         fwd_ff      <= hist_we && (hist_wa == req_idx);
         fwd_data_ff <= hist_wd;
      end
   end

   // Pass total, running sum and the map-built flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         cum_ff   <= '0;
         built_ff <= 1'b0;
      end else if (cmd.finish) begin
         total_ff <= '0;
         cum_ff   <= '0;
         built_ff <= 1'b1;
      end else begin
         if (cmd.acc_fire && counted) begin
            total_ff <= CNT_W'(total_ff + 1'b1);
         end
         if (cmd.cum_add) begin
            cum_ff <= CNT_W'(cum_ff + hist_rd_ff);
         end
      end
   end

   // Scaled numerator with the rounding half of the total.
   assign num = NUM_W'(NUM_W'(LVL_TOP) * NUM_W'(cum_ff)) + NUM_W'(total_ff >> 1);

   // Restoring divider, one quotient bit per step; the quotient fits the level width.
   assign div_shift = {div_rem_ff, div_lo_ff[LVL_W-1]};
   assign div_ge    = div_shift >= {1'b0, total_ff};

   always_comb begin
      div_rem_in = div_rem_ff;
      div_lo_in  = div_lo_ff;
      if (cmd.mul_load) begin
         div_rem_in = num[NUM_W-1:LVL_W];
         div_lo_in  = num[LVL_W-1:0];
      end else if (cmd.div_step) begin
         div_rem_in = div_ge ? CNT_W'(div_shift - {1'b0, total_ff}) : CNT_W'(div_shift);
         div_lo_in  = LVL_W'(div_lo_ff << 1) | LVL_W'(div_ge);
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_lo_ff  <= div_lo_in;
   end

   // An empty pass maps every level to zero.
   assign map_wd = (total_ff == '0) ? '0 : MAPPED_W'(div_lo_ff);

   // Level map store; entries before the first build read as zero.
   always_ff @(posedge clock) begin
      if (cmd.map_wr) begin
         map_mem[idx] <= map_wd;
      end
      if (cmd.map_fire) begin
         map_rd_ff   <= map_mem[req_idx];
         mrd_zero_ff <= !built_ff;
      end
   end

   // Map read stage feeding the response register.
   assign rsp_load      = mrd_ff && (!rsp_valid_ff || rsp_ready);
   assign sts.slot_free = !mrd_ff || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         mrd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.map_fire) begin
            mrd_ff <= 1'b1;
         end else if (rsp_load) begin
            mrd_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rsp_mapped_ff <= mrd_zero_ff ? '0 : map_rd_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_mapped = rsp_mapped_ff;

`ifndef SYNTHESIS
   // Clearing and the increment never compete for the histogram write port.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_wr && inc_pend_ff))
      else $error("histogram write port conflict");

   // The pass total saturates at the pixel limit.
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_MAX)
      else $error("pixel total beyond its limit");

   // The running sum never passes the total of the pass.
   a_cum_bound: assert property (@(posedge clock) disable iff (reset)
      cum_ff <= total_ff)
      else $error("running sum exceeds pixel total");
`endif

endmodule

/* design/histogram_equalizer.sv */
// Top level of the histogram equalizer.
//
// Requests arrive on req_valid/req_ready with req_type, req_pixel and req_last.
// An accumulate transaction (req_type 0) counts one pixel into the histogram and
// gives no response; the block takes one per cycle while req_ready is high,
// through a read-increment-write pipeline on the histogram memory with forwarding
// between neighboring pixels. An accumulate transaction with req_last set closes
// the pass: the block then walks all LEVELS entries, one at a time, and accepts
// nothing until the walk ends. For each level it reads and clears the histogram
// entry, adds it to the running sum, forms the scaled numerator, divides it by the
// pass total in the serial divider and writes the quotient into the level map.
// A map transaction (req_type 1) returns the equalized level on rsp_mapped through
// the map read stage and the output register, one per cycle when rsp_ready is high.
// A stalled response holds in the output register; one more map transaction can
// wait in the read stage behind it before req_ready drops.
// After reset the histogram memory is cleared, one entry a cycle, with req_ready
// low; the level map reads as zero until the first build.
module histogram_equalizer #(
   parameter int LEVELS     = histeq_pkg::DEF_LEVELS,
   parameter int MAX_PIXELS = histeq_pkg::DEF_MAX_PIXELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [histeq_pkg::PIXEL_W-1:0]  req_pixel,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [histeq_pkg::MAPPED_W-1:0] rsp_mapped
);
   import histeq_pkg::*;

   localparam int LVL_W = $clog2(LEVELS);

   histeq_cmd_type   cmd;
   histeq_sts_type   sts;
   logic [LVL_W-1:0] idx;

   // Sequencing of transactions and of the build walk.
   histeq_ctrl #(
      .LEVELS (LEVELS),
      .LVL_W  (LVL_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_last  (req_last),
      .sts       (sts),
      .cmd       (cmd),
      .idx       (idx)
   );

   // Histogram, level map, arithmetic and the response register.
   histeq_dp #(
      .LEVELS     (LEVELS),
      .MAX_PIXELS (MAX_PIXELS),
      .LVL_W      (LVL_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_pixel  (req_pixel),
      .cmd        (cmd),
      .idx        (idx),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_mapped (rsp_mapped)
   );

endmodule

/* test/tb_histogram_equalizer.sv */
// Self-checking testbench for the histogram equalizer against a predicted level map.
module tb_histogram_equalizer;
   timeunit 1ns;
   timeprecision 1ps;

   import histeq_pkg::*;

   localparam int LEVELS       = DEF_LEVELS;
   localparam int MAX_PIXELS   = DEF_MAX_PIXELS;
   localparam int ITEM_TARGET  = 1300;
   localparam int BUILD_CAP    = 12;
   // Longest correct silence is one map build; the limit allows several.
   localparam int QUIET_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic               kind;
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } pixel_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [MAPPED_W-1:0] mapped;
   } mapped_expect_type;

   logic                clock = 1'b1;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_type = REQ_ACCUM;
   logic [PIXEL_W-1:0]  req_pixel = '0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [MAPPED_W-1:0] rsp_mapped;

   // Stimulus and scoreboard storage.
   pixel_req_type     request_queue[$];
   mapped_expect_type mapped_expected[$];
   int                error_count = 0;
   int                quiet_cycles = 0;
   logic              no_idle = 1'b0;

   // Predicted block state.
   int unsigned         level_count[LEVELS];
   logic [MAPPED_W-1:0] level_map_model[LEVELS];
   int unsigned         pass_pixels;

   // Stimulus generation bookkeeping.
   int item_total = 0;
   int build_total = 0;

   histogram_equalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_type),
      .req_pixel  (req_pixel),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_mapped (rsp_mapped)
   );

   always begin
      #5 clock = 1'b0;
      #5 clock = 1'b1;
   end

   // Pixels beyond the top level are treated as the top level.
   function automatic int unsigned saturate_level(logic [PIXEL_W-1:0] pixel);
      if (int'(pixel) > LEVELS - 1) begin
         return LEVELS - 1;
      end
      return 32'(pixel);
   endfunction

   // Walk the histogram, form the rounded equalization map, then start a new pass.
   function automatic void build_level_map();
      longint unsigned cum;
      longint unsigned scaled;
      cum = 0;
      for (int i = 0; i < LEVELS; i++) begin
         cum += level_count[i];
         if (pass_pixels == 0) begin
            level_map_model[i] = '0;
         end else begin
            scaled = (longint'(LEVELS - 1) * cum + pass_pixels / 2) / pass_pixels;
            level_map_model[i] = scaled[MAPPED_W-1:0];
         end
      end
      for (int i = 0; i < LEVELS; i++) begin
         level_count[i] = 0;
      end
      pass_pixels = 0;
   endfunction

   // Update the predicted state for one accepted request; queue the expected response.
   function automatic void account_request(pixel_req_type item);
      int unsigned       level;
      mapped_expect_type want;
      level = saturate_level(item.pixel);
      if (item.kind == REQ_ACCUM) begin
         if (pass_pixels < MAX_PIXELS) begin
            level_count[level]++;
            pass_pixels++;
         end
         if (item.last) begin
            build_level_map();
         end
      end else begin
         want.pixel  = item.pixel;
         want.mapped = level_map_model[level];
         mapped_expected.push_back(want);
      end
   endfunction

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic void push_request(logic kind, int pixel, logic last);
      pixel_req_type item;
      item.kind  = kind;
      item.pixel = pixel[PIXEL_W-1:0];
      item.last  = last;
      request_queue.push_back(item);
      item_total++;
      if (kind == REQ_ACCUM && last) begin
         build_total++;
      end
   endfunction

   // Pick a pixel according to the distribution chosen for the current pass.
   function automatic int pick_pixel(int shape, int lo, int span);
      case (shape)
         0: begin
            return $urandom_range(0, LEVELS - 1);
         end
         1: begin
            return lo + $urandom_range(0, span);
         end
         2: begin
            return ($urandom_range(0, 1) != 0) ? lo + $urandom_range(0, span)
                                               : (LEVELS - 1) - $urandom_range(0, span);
         end
         default: begin
            return ($urandom_range(0, 1) != 0) ? 0 : LEVELS - 1;
         end
      endcase
   endfunction

   // Directed opening, then random accumulate passes each followed by map traffic.
   task automatic fill_requests();
      int shape;
      int lo;
      int span;
      int acc_len;
      int map_len;
      // Map before any build returns zeros; last on a map transaction is ignored.
      push_request(REQ_MAP, 0, 1'b0);
      push_request(REQ_MAP, LEVELS - 1, 1'b1);
      // Small pass over the extremes and alternating bit patterns.
      push_request(REQ_ACCUM, 0, 1'b0);
      push_request(REQ_ACCUM, 0, 1'b0);
      push_request(REQ_ACCUM, LEVELS - 1, 1'b0);
      push_request(REQ_ACCUM, 2048, 1'b0);
      push_request(REQ_ACCUM, 1, 1'b0);
      push_request(REQ_ACCUM, 4094, 1'b0);
      push_request(REQ_ACCUM, 'h555, 1'b0);
      push_request(REQ_ACCUM, 'hAAA, 1'b1);
      push_request(REQ_MAP, 0, 1'b0);
      push_request(REQ_MAP, 1, 1'b0);
      push_request(REQ_MAP, 2047, 1'b0);
      push_request(REQ_MAP, 2048, 1'b1);
      push_request(REQ_MAP, 4094, 1'b0);
      push_request(REQ_MAP, LEVELS - 1, 1'b0);
      push_request(REQ_MAP, 'h555, 1'b0);
      push_request(REQ_MAP, 'hAAA, 1'b0);
      // A pass of a single pixel.
      push_request(REQ_ACCUM, 3000, 1'b1);
      push_request(REQ_MAP, 2999, 1'b0);
      push_request(REQ_MAP, 3000, 1'b0);
      push_request(REQ_MAP, 0, 1'b0);

      // Random passes: mostly well-formed, with stray transactions of the other kind.
      while (item_total < ITEM_TARGET && build_total < BUILD_CAP) begin
         shape   = $urandom_range(0, 3);
         span    = $urandom_range(0, 200);
         lo      = $urandom_range(0, LEVELS - 1 - span);
         acc_len = $urandom_range(30, 150);
         map_len = $urandom_range(40, 120);
         for (int n = 0; n < acc_len; n++) begin
            if ($urandom_range(0, 99) < 8) begin
               push_request(REQ_MAP, pick_pixel(shape, lo, span), 1'($urandom_range(0, 1)));
            end
            push_request(REQ_ACCUM, pick_pixel(shape, lo, span), n == acc_len - 1);
         end
         for (int n = 0; n < map_len; n++) begin
            if ($urandom_range(0, 99) < 8) begin
               push_request(REQ_ACCUM, pick_pixel(shape, lo, span), 1'b0);
            end else if ($urandom_range(0, 1) != 0) begin
               push_request(REQ_MAP, pick_pixel(shape, lo, span), 1'($urandom_range(0, 1)));
            end else begin
               push_request(REQ_MAP, $urandom_range(0, LEVELS - 1),
                            1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   // Request driver: predicts each accepted transaction, then presents the next one.
   int            req_gap = 0;
   pixel_req_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            account_request('{kind: req_type, pixel: req_pixel, last: req_last});
            if ($urandom_range(0, 39) == 0) begin
               no_idle <= !no_idle;
            end
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap--;
            end else if (request_queue.size() != 0) begin
               next_req = request_queue.pop_front();
               req_type  <= next_req.kind;
               req_pixel <= next_req.pixel;
               req_last  <= next_req.last;
               req_valid <= 1'b1;
               req_gap = draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random back-pressure and in-order comparison.
   int                rsp_stall = 0;
   mapped_expect_type oldest;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mapped_expected.size() == 0) begin
               $display("%0t: unexpected response transaction, mapped %0d", $time, rsp_mapped);
               error_count++;
            end else begin
               oldest = mapped_expected.pop_front();
               if (rsp_mapped !== oldest.mapped) begin
                  $display("%0t: mapped mismatch for pixel %0d: expected %0d, actual %0d",
                           $time, oldest.pixel, oldest.mapped, rsp_mapped);
                  error_count++;
               end
            end
            rsp_stall = draw_wait();
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // Count cycles in which no transaction completes on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("tb_histogram_equalizer: errors");
      $finish;
   end

   // Reset, run the stimulus to completion, drain the responses and report.
   initial begin
      for (int i = 0; i < LEVELS; i++) begin
         level_count[i]     = 0;
         level_map_model[i] = '0;
      end
      pass_pixels = 0;
      fill_requests();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (request_queue.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (mapped_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_histogram_equalizer: clean");
      end else begin
         $display("tb_histogram_equalizer: errors");
      end
      $finish;
   end

endmodule
